FILE: sv/r41_pkg.sv
// Shared types and constants for the radix-41 text decoder.
package r41_pkg;

  localparam int unsigned SymLow   = 41;
  localparam int unsigned SymHigh  = 82;
  localparam int unsigned Radix    = 41;
  localparam int unsigned RadixSq  = 41 * 41;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);
  localparam int unsigned PosWidth = 3;
  localparam int unsigned AccWidth = 17;
  localparam int unsigned PaddrW   = 3;

  localparam logic [PosWidth-1:0] PosPairDone = 3'd6;

  typedef enum logic [1:0] {
    MODE_BYTES = 2'd0,
    MODE_WORD  = 2'd1,
    MODE_DWORD = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SYMBOL = 2'd1,
    ST_OPEN_GROUP = 2'd2
  } status_t;

  localparam logic [PaddrW-1:0] RegOutputMode = 3'd0;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } result_t;

  // One queued command: one or two results caused by one input transaction.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
    cmd_t head;
  } q_status_t;

endpackage

FILE: sv/r41_in_if.sv
// Input channel: one text symbol per transaction.
interface r41_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_string;

  modport source (output valid, symbol, end_of_string, input ready);
  modport sink   (input valid, symbol, end_of_string, output ready);
endinterface

FILE: sv/r41_out_if.sv
// Result channel: decoded value with status and last flag.
interface r41_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, value, status, last, input ready);
  modport sink   (input valid, value, status, last, output ready);
endinterface

FILE: sv/r41_front.sv
// Front end: accepts symbols, checks range, accumulates groups, issues commands.
module r41_front import r41_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  mode_t         mode,
  r41_in_if.sink        in_ch,
  input  logic          q_full,
  output push_t         push_o
);

  logic [PosWidth-1:0] pos_r, pos_nxt;
  logic [AccWidth-1:0] acc_r, acc_nxt;
  logic [15:0]         low_r, low_nxt;

  logic                accept;
  logic                bad;
  logic [5:0]          digit;
  logic [1:0]          didx;
  logic [AccWidth-1:0] acc_sum;
  logic [PosWidth-1:0] pos_inc;
  logic [15:0]         grp;
  logic                has_res;
  cmd_t                cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    bad     = !(in_ch.symbol inside {[SymLow:SymHigh]});
    digit   = 6'(in_ch.symbol - 8'(SymLow));
    didx    = (pos_r >= 3'd3) ? 2'(pos_r - 3'd3) : pos_r[1:0];
    pos_inc = pos_r + 3'd1;
    case (didx)
      2'd0:    acc_sum = AccWidth'(digit);
      2'd1:    acc_sum = acc_r + AccWidth'(AccWidth'(digit) * AccWidth'(Radix));
      default: acc_sum = acc_r + AccWidth'(AccWidth'(digit) * AccWidth'(RadixSq));
    endcase
    grp = acc_sum[15:0];

    pos_nxt = pos_r;
    acc_nxt = acc_r;
    low_nxt = low_r;
    has_res = 1'b0;
    cmd     = '0;

    if (bad) begin
      pos_nxt            = '0;
      acc_nxt            = '0;
      low_nxt            = '0;
      has_res            = 1'b1;
      cmd.res0.status    = ST_BAD_SYMBOL;
    end else begin
      pos_nxt = pos_inc;
      acc_nxt = acc_sum;
      if (didx == 2'd2) begin
        acc_nxt = '0;
        case (mode)
          MODE_BYTES: begin
            has_res         = 1'b1;
            cmd.two         = 1'b1;
            cmd.res0.value  = {24'd0, grp[7:0]};
            cmd.res1.value  = {24'd0, grp[15:8]};
            pos_nxt         = '0;
          end
          MODE_DWORD: begin
            if (pos_inc >= PosPairDone) begin
              has_res        = 1'b1;
              cmd.res0.value = {grp, low_r};
              pos_nxt        = '0;
              low_nxt        = '0;
            end else begin
              low_nxt = grp;
            end
          end
          default: begin
            has_res        = 1'b1;
            cmd.res0.value = {16'd0, grp};
            pos_nxt        = '0;
          end
        endcase
      end
      if (in_ch.end_of_string && pos_nxt != '0) begin
        pos_nxt = '0;
        acc_nxt = '0;
        low_nxt = '0;
        if (has_res) begin
          cmd.two         = 1'b1;
          cmd.res1.value  = '0;
          cmd.res1.status = ST_OPEN_GROUP;
        end else begin
          has_res         = 1'b1;
          cmd.res0.value  = '0;
          cmd.res0.status = ST_OPEN_GROUP;
        end
      end
    end
  end

  assign push_o.push = accept && has_res;
  assign push_o.cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
      low_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      low_r <= low_nxt;
    end
  end

endmodule

FILE: sv/r41_queue.sv
// Command queue between front end and result sequencer.
module r41_queue import r41_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push_i,
  input  logic      pop,
  output q_status_t q_o
);

  cmd_t           mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAw:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign q_o.empty = (cnt_r == '0);
  assign q_o.full  = (cnt_r == (QAw+1)'(QDepth));
  assign q_o.head  = mem_r[rd_ptr_r];

  assign do_push = push_i.push && !q_o.full;
  assign do_pop  = pop && !q_o.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_i.cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

FILE: sv/r41_back.sv
// Back end: expands queued commands into result transactions.
module r41_back import r41_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_i,
  output logic      pop,
  r41_out_if.source out_ch
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  result_t     res_r, res_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic        is_last;

  assign load    = !valid_r || out_ch.ready;
  assign is_last = !q_i.head.two || phase_r;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !q_i.empty;
      if (!q_i.empty) begin
        res_nxt   = phase_r ? q_i.head.res1 : q_i.head.res0;
        last_nxt  = is_last;
        pop       = is_last;
        phase_nxt = !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid  = valid_r;
  assign out_ch.value  = res_r.value;
  assign out_ch.status = res_r.status;
  assign out_ch.last   = last_r;

endmodule

FILE: sv/radix41_text_decoder_top.sv
// Radix-41 text decoder: one symbol per input transaction, results out with
// a status code and a last flag. The front end takes one symbol every clock
// while its four-entry command queue has room; the per-symbol work is a
// constant multiply-add and a range check. The result sequencer emits one
// result transaction per clock while the sink is ready. No symbol yields more
// than two results, and a two-result symbol is always preceded by two that
// yield none, so the input keeps one symbol per clock in every mode unless the
// sink stalls. Write output_mode only while idle.
module radix41_text_decoder_top import r41_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  r41_in_if.sink             in_ch,
  r41_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  mode_t     mode_r;
  push_t     push;
  q_status_t q_stat;
  logic      pop;
  logic      sel_mode;

  assign pready   = 1'b1;
  assign sel_mode = ({paddr[PaddrW-1:2], 2'b00} == RegOutputMode);
  assign prdata   = sel_mode ? {30'd0, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BYTES;
    end else if (psel && penable && pwrite && pready && sel_mode) begin
      mode_r <= mode_t'(pwdata[1:0]);
    end
  end

  r41_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .mode   (mode_r),
    .in_ch  (in_ch),
    .q_full (q_stat.full),
    .push_o (push)
  );

  r41_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .q_o    (q_stat)
  );

  r41_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_i    (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: bench/tb_radix41_text_decoder_top.sv
// Self-checking bench for the radix-41 text decoder: directed table, random strings, mode sweeps.
module tb_radix41_text_decoder_top;
  import r41_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned Limit = 200000;
  localparam int unsigned Settle = 6;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
    logic        last;
  } outcome_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  sym;
    logic        eos;
    logic        typed;
    logic [31:0] value;
    status_t     status;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  r41_in_if  in_ch ();
  r41_out_if out_ch ();

  radix41_text_decoder_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // decoder state mirror
  logic [2:0]  dpos;
  logic [16:0] acc;
  logic [15:0] low_half;
  logic [1:0]  mode_reg;

  outcome_t awaited[$];
  int unsigned n_bad;
  int unsigned cycles;
  int unsigned idle_pct;

  // directed table: typed rows carry their single expected result
  stim_row_t plan [25] = '{
    '{MODE_BYTES, 8'd41,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_BYTES, 8'd41,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_BYTES, 8'd41,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_BYTES, 8'd82,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_BYTES, 8'd82,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_BYTES, 8'd82,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_BYTES, 8'd0,   1'b0, 1'b1, 32'd0, ST_BAD_SYMBOL},
    '{MODE_BYTES, 8'd40,  1'b0, 1'b1, 32'd0, ST_BAD_SYMBOL},
    '{MODE_BYTES, 8'd83,  1'b1, 1'b1, 32'd0, ST_BAD_SYMBOL},
    '{MODE_BYTES, 8'd50,  1'b1, 1'b1, 32'd0, ST_OPEN_GROUP},
    '{MODE_WORD,  8'd41,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_WORD,  8'd41,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_WORD,  8'd41,  1'b0, 1'b1, 32'd0, ST_OK},
    '{MODE_WORD,  8'd82,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_WORD,  8'd82,  1'b1, 1'b0, 32'd0, ST_OK},
    '{MODE_DWORD, 8'd82,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_DWORD, 8'd82,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_DWORD, 8'd82,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_DWORD, 8'd45,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_DWORD, 8'd45,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_DWORD, 8'd45,  1'b0, 1'b0, 32'd0, ST_OK},
    '{MODE_DWORD, 8'd50,  1'b0, 1'b0, 32'd0, ST_OK},
    '{ModeSpare,  8'd41,  1'b0, 1'b0, 32'd0, ST_OK},
    '{ModeSpare,  8'd42,  1'b0, 1'b0, 32'd0, ST_OK},
    '{ModeSpare,  8'd43,  1'b1, 1'b0, 32'd0, ST_OK}
  };

  function automatic outcome_t result_of(logic [31:0] v, status_t s);
    outcome_t o;
    o.value  = v;
    o.status = s;
    o.last   = 1'b0;
    return o;
  endfunction

  function automatic void clear_group();
    dpos     = '0;
    acc      = '0;
    low_half = '0;
  endfunction

  // advance the mirror by one symbol; queue its results when keep is set
  function automatic void decode_symbol(logic [7:0] sym, logic eos, bit keep);
    outcome_t    r[$];
    logic [2:0]  pos;
    logic [2:0]  didx;
    logic [7:0]  digit;
    logic [15:0] grp;
    pos  = dpos;
    didx = (pos >= 3'd3) ? pos - 3'd3 : pos;
    if (sym < SymLow || sym > SymHigh) begin
      clear_group();
      r.push_back(result_of(32'd0, ST_BAD_SYMBOL));
    end else begin
      digit = 8'(sym - SymLow);
      case (didx)
        3'd0: acc = 17'(digit);
        3'd1: acc = 17'(acc + Radix * digit);
        default: acc = 17'(acc + RadixSq * digit);
      endcase
      pos = pos + 3'd1;
      if (didx == 3'd2) begin
        grp = acc[15:0];
        acc = '0;
        if (mode_reg == MODE_BYTES) begin
          r.push_back(result_of({24'd0, grp[7:0]}, ST_OK));
          r.push_back(result_of({24'd0, grp[15:8]}, ST_OK));
          pos = '0;
        end else if (mode_reg == MODE_DWORD) begin
          if (pos >= PosPairDone) begin
            r.push_back(result_of({grp, low_half}, ST_OK));
            pos      = '0;
            low_half = '0;
          end else begin
            low_half = grp;
          end
        end else begin
          r.push_back(result_of({16'd0, grp}, ST_OK));
          pos = '0;
        end
      end
      dpos = pos;
      if (eos && dpos != 3'd0) begin
        clear_group();
        r.push_back(result_of(32'd0, ST_OPEN_GROUP));
      end
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    if (keep) foreach (r[i]) awaited.push_back(r[i]);
  endfunction

  task automatic flag_mismatch(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic send_symbol(input logic [7:0] sym, input logic eos, input bit typed,
                             input outcome_t typed_out);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.symbol        <= sym;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    decode_symbol(sym, eos, !typed);
    if (typed) awaited.push_back(typed_out);
  endtask

  // drain, let in-flight symbols settle, then write and read back the mode
  task automatic set_output_mode(input logic [1:0] m);
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegOutputMode;
    pwdata  <= {30'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_reg = m;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[1:0] !== m)
      flag_mismatch($sformatf("output_mode readback exp %0d got %0d", m, prdata[1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("radix41_text_decoder_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    out_ch.ready <= ($urandom_range(99) >= idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value %h status %0d last %0b",
                                out_ch.value, out_ch.status, out_ch.last));
      end else begin
        want = awaited.pop_front();
        if (out_ch.value !== want.value || out_ch.status !== want.status ||
            out_ch.last !== want.last)
          flag_mismatch($sformatf("result exp %h/%0d/%0b got %h/%0d/%0b",
                                  want.value, want.status, want.last,
                                  out_ch.value, out_ch.status, out_ch.last));
      end
    end
  end

  initial begin : stimulus
    outcome_t   fixed;
    logic [7:0] sym;
    logic       eos;
    int unsigned pick;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.symbol        = '0;
    in_ch.end_of_string = 1'b0;
    n_bad               = 0;
    idle_pct            = 12;
    mode_reg            = MODE_BYTES;
    clear_group();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].mode != mode_reg) set_output_mode(plan[i].mode);
      fixed      = result_of(plan[i].value, plan[i].status);
      fixed.last = 1'b1;
      send_symbol(plan[i].sym, plan[i].eos, plan[i].typed, fixed);
    end

    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph == 4) ? 0 : 12;
      case (ph)
        0: set_output_mode(MODE_BYTES);
        1: set_output_mode(ModeSpare);
        2: set_output_mode(MODE_DWORD);
        3: set_output_mode(MODE_WORD);
        default: set_output_mode(2'($urandom_range(3)));
      endcase
      repeat (70) begin
        pick = $urandom_range(99);
        if (pick < 3)       sym = 8'($urandom_range(40));
        else if (pick < 7)  sym = 8'($urandom_range(255, 83));
        else if (pick < 12) sym = 8'(SymLow);
        else if (pick < 17) sym = 8'(SymHigh);
        else                sym = 8'($urandom_range(SymHigh, SymLow));
        eos = ($urandom_range(9) == 0);
        send_symbol(sym, eos, 1'b0, fixed);
      end
    end

    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0) begin
      $display("radix41_text_decoder_top: match");
    end else begin
      $display("radix41_text_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
